>>> sv/ddsl_pkg.sv
// Shared types, constants and helpers for the differential drive slew limiter.
// No dependencies; imported by ddsl_slew and differential_drive_slew_limiter.
package ddsl_pkg;

  typedef logic [7:0] duty_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_SPEED = 2'd0,
    REG_MAX_SPEED  = 2'd1,
    REG_ACCEL_MIN  = 2'd2,
    REG_ACCEL_MAX  = 2'd3
  } cfg_reg_t;

  // Line error full scale; the error magnitude saturates here
  localparam int unsigned ERR_FULL_SCALE = 3500;
  localparam int unsigned ERR_MAG_W      = 12;
  // |error| * |accel_max - accel_min| is at most 3500 * 255 < 2**20
  localparam int unsigned PROD_W         = 20;

  // floor(x / 3500) = (x * RECIP_3500) >> RECIP_SHIFT, exact for x < 2**20
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_3500 = 21'd1227134;

  // Clamp a signed value into 0..hi
  function automatic duty_t clamp_duty(input logic signed [17:0] v, input duty_t hi);
    logic signed [17:0] hi_s;
    hi_s = signed'({10'b0, hi});
    if (v < 18'sd0) begin
      return '0;
    end else if (v > hi_s) begin
      return hi;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

>>> sv/ddsl_slew.sv
// One wheel of the slew limiter: moves a stored duty toward its target by at
// most one step, then clamps to 0..max_speed. Depends on ddsl_pkg.
module ddsl_slew
  import ddsl_pkg::*;
(
  input  duty_t cur,
  input  duty_t target,
  input  duty_t step,
  input  duty_t hi,
  output duty_t nxt
);

  logic signed [8:0]  diff;
  logic        [8:0]  mag;
  logic signed [17:0] moved;

  // Distance to the target
  assign diff = signed'({1'b0, target}) - signed'({1'b0, cur});
  assign mag  = diff[8] ? 9'(-diff) : 9'(diff);

  // Step toward the target, or land on it when close enough
  always_comb begin
    if (mag > {1'b0, step}) begin
      if (diff > 9'sd0) begin
        moved = signed'({10'b0, cur}) + signed'({10'b0, step});
      end else begin
        moved = signed'({10'b0, cur}) - signed'({10'b0, step});
      end
    end else begin
      moved = signed'({10'b0, target});
    end
  end

  assign nxt = clamp_duty(moved, hi);

endmodule

>>> sv/differential_drive_slew_limiter.sv
// Top level of the differential drive mixer with per-tick slew limiting.
// Depends on ddsl_pkg and ddsl_slew.
//
// Each input beat carries a steering correction and a line error; each one
// yields exactly one output beat with the new left and right wheel duties.
// The block takes one beat per clock cycle while the output side is not
// stalled, and each result moves through the stages below in order.
// The four registered stages are: input capture; targets and the
// |error| * |accel_max - accel_min| product; the divide by 3500, done as a
// multiply by a fixed reciprocal, and the step limit; and the output register,
// which also holds the stored wheel speeds that each new tick slews from.
// Back-pressure ripples through the stages, so empty stages keep filling while
// a result waits. Configuration writes take effect at once and should be made
// only while no beat is in flight.
module differential_drive_slew_limiter
  import ddsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] correction, [31:16] line_error
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] left_duty, [15:8] right_duty
);

  // Configuration registers
  duty_t base_speed;
  duty_t max_speed;
  duty_t accel_min;
  duty_t accel_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed <= 8'd0;
      max_speed  <= 8'd255;
      accel_min  <= 8'd0;
      accel_max  <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_BASE_SPEED: base_speed <= cfg_wdata;
        REG_MAX_SPEED:  max_speed  <= cfg_wdata;
        REG_ACCEL_MIN:  accel_min  <= cfg_wdata;
        REG_ACCEL_MAX:  accel_max  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage handshakes
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy_o;

  assign rdy_o    = !m_tvalid || m_tready;
  assign rdy3     = !v3 || rdy_o;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // Stage 1: input capture
  logic signed [15:0] s1_corr;
  logic signed [15:0] s1_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy1) begin
      s1_corr <= signed'(s_tdata[15:0]);
      s1_err  <= signed'(s_tdata[31:16]);
    end
  end

  // Stage 2: clamped targets, saturated error magnitude and product
  logic        [16:0]          err_abs;
  logic        [ERR_MAG_W-1:0] err_mag;
  logic                        acc_neg;
  logic        [7:0]           acc_span;
  logic        [PROD_W-1:0]    prod;
  logic signed [17:0]          base_s;
  logic signed [17:0]          corr_s;
  duty_t                       tl, tr;

  assign err_abs  = s1_err[15] ? 17'(-signed'({s1_err[15], s1_err})) : {1'b0, s1_err};
  assign err_mag  = (err_abs > 17'(ERR_FULL_SCALE)) ? ERR_MAG_W'(ERR_FULL_SCALE)
                                                    : err_abs[ERR_MAG_W-1:0];
  assign acc_neg  = accel_max < accel_min;
  assign acc_span = acc_neg ? (accel_min - accel_max) : (accel_max - accel_min);
  assign prod     = PROD_W'(err_mag) * PROD_W'(acc_span);

  assign base_s = signed'({10'b0, base_speed});
  assign corr_s = 18'(s1_corr);
  assign tl     = clamp_duty(base_s - corr_s, max_speed);
  assign tr     = clamp_duty(base_s + corr_s, max_speed);

  logic [PROD_W-1:0] s2_prod;
  logic              s2_neg;
  duty_t             s2_tl, s2_tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      s2_prod <= prod;
      s2_neg  <= acc_neg;
      s2_tl   <= tl;
      s2_tr   <= tr;
    end
  end

  // Stage 3: divide by 3500 through the reciprocal, then the step limit
  localparam int unsigned QF_W = PROD_W + RECIP_W;

  logic        [QF_W-1:0] q_full;
  logic        [7:0]      quot;
  logic signed [9:0]      quot_s;
  logic signed [9:0]      step_s;

  assign q_full = QF_W'(s2_prod) * QF_W'(RECIP_3500);
  assign quot   = q_full[RECIP_SHIFT +: 8];
  assign quot_s = signed'({2'b0, quot});
  assign step_s = signed'({2'b0, accel_min}) + (s2_neg ? -quot_s : quot_s);

  duty_t s3_step;
  duty_t s3_tl, s3_tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      s3_step <= step_s[7:0];
      s3_tl   <= s2_tl;
      s3_tr   <= s2_tr;
    end
  end

  // Stage 4: slew the stored wheel speeds; they double as the output register
  duty_t left_speed, right_speed;
  duty_t left_next, right_next;

  ddsl_slew u_slew_left (
    .cur    (left_speed),
    .target (s3_tl),
    .step   (s3_step),
    .hi     (max_speed),
    .nxt    (left_next)
  );

  ddsl_slew u_slew_right (
    .cur    (right_speed),
    .target (s3_tr),
    .step   (s3_step),
    .hi     (max_speed),
    .nxt    (right_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      left_speed  <= '0;
      right_speed <= '0;
    end else begin
      if (rdy_o) begin
        m_tvalid <= v3;
      end
      if (v3 && rdy_o) begin
        left_speed  <= left_next;
        right_speed <= right_next;
      end
    end
  end

  assign m_tdata = {right_speed, left_speed};

`ifndef SYNTH
  // Input stalls only when every stage is full
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && m_tvalid))
    else $error("input stalled with an empty stage");

  // A new result never exceeds the clamp that was in force when it was formed
  a_duty_clamped: assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy_o) |=> (left_speed <= $past(max_speed) && right_speed <= $past(max_speed)))
    else $error("wheel duty above max_speed");

  // A beat in the last stage is kept while the output is blocked
  a_stage3_held: assert property (@(posedge clk) disable iff (rst)
    (v3 && !rdy_o) |=> v3)
    else $error("stage 3 beat dropped under back-pressure");

  // Wheel state changes only when a beat moves into the output register
  a_state_moves_on_load: assert property (@(posedge clk) disable iff (rst)
    !(v3 && rdy_o) |=> ($stable(left_speed) && $stable(right_speed)))
    else $error("wheel state changed without a beat");
`endif

endmodule

>>> tb/sv/differential_drive_slew_limiter_tb.sv
// Self-checking testbench for differential_drive_slew_limiter: a directed table, then
// random ticks under several register settings, each checked against table or predictor.
// Depends on ddsl_pkg and the RTL of the block; reads no files.
module differential_drive_slew_limiter_tb;
  import ddsl_pkg::*;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_TICKS = 163;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    duty_t left;
    duty_t right;
  } duty_pair_t;

  // One row of the directed table: a register write or a tick, maybe with known duties
  typedef struct {
    bit          is_cfg;
    cfg_reg_t    reg_idx;
    logic [7:0]  val;
    logic [15:0] corr;
    logic [15:0] err;
    bit          known;
    duty_t       want_l;
    duty_t       want_r;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [15:0] correction, [31:16] line_error
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] left_duty, [15:8] right_duty

  // Predictor copy of the registers and wheel speeds
  logic [7:0]  cur_base, cur_max, cur_amin, cur_amax;
  duty_t       whl_l, whl_r;

  duty_pair_t  duty_q[$];
  dir_row_t    dir_tbl[$];
  int unsigned mismatches = 0;
  bit          hold_trigger = 1'b0;

  differential_drive_slew_limiter i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int clamp_to(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic duty_t slew_toward(input duty_t cur, input int tgt, input int lim,
                                        input int hi);
    int c;
    int diff;
    int abs_diff;
    c        = int'(cur);
    diff     = tgt - c;
    abs_diff = (diff < 0) ? -diff : diff;
    if (abs_diff > lim) c += (diff > 0) ? lim : -lim;
    else                c = tgt;
    return duty_t'(clamp_to(c, hi));
  endfunction

  // Mix one tick into wheel targets, slew the stored speeds, return the new duties
  function automatic duty_pair_t mix_and_slew(input logic [15:0] corr_bits,
                                              input logic [15:0] err_bits);
    int         corr;
    int         err;
    int         hi;
    int         mag;
    int         lim;
    duty_pair_t p;
    corr = $signed(corr_bits);
    err  = $signed(err_bits);
    hi   = int'(cur_max);
    mag  = (err < 0) ? -err : err;
    if (mag > int'(ERR_FULL_SCALE)) mag = int'(ERR_FULL_SCALE);
    lim  = int'(cur_amin) + (mag * (int'(cur_amax) - int'(cur_amin))) / int'(ERR_FULL_SCALE);
    whl_l = slew_toward(whl_l, clamp_to(int'(cur_base) - corr, hi), lim, hi);
    whl_r = slew_toward(whl_r, clamp_to(int'(cur_base) + corr, hi), lim, hi);
    p.left  = whl_l;
    p.right = whl_r;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Small values, full range, values around a knee, or the extremes
  function automatic logic [15:0] rand_field(input int unsigned span, input int unsigned knee);
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      v = int'($urandom_range(0, 2 * span)) - int'(span);
    end else if (r < 7) begin
      v = int'($urandom_range(0, 65535));
    end else if (r < 9) begin
      v = int'(knee) + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      case ($urandom_range(0, 2))
        0:       v = 32767;
        1:       v = -32768;
        default: v = 0;
      endcase
    end
    return v[15:0];
  endfunction

  function automatic logic [7:0] rand_reg_val();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic dir_row_t cfg_row(input cfg_reg_t r, input logic [7:0] v);
    dir_row_t row;
    row = '{reg_idx: REG_BASE_SPEED, default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = r;
    row.val     = v;
    return row;
  endfunction

  function automatic dir_row_t tick_row(input logic [15:0] c, input logic [15:0] e);
    dir_row_t row;
    row = '{reg_idx: REG_BASE_SPEED, default: '0};
    row.corr = c;
    row.err  = e;
    return row;
  endfunction

  function automatic dir_row_t known_row(input logic [15:0] c, input logic [15:0] e,
                                         input duty_t l, input duty_t r);
    dir_row_t row;
    row = tick_row(c, e);
    row.known  = 1'b1;
    row.want_l = l;
    row.want_r = r;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one tick, predict at acceptance, then idle for a random gap unless bursting
  task automatic send_tick(input logic [15:0] c, input logic [15:0] e, input bit burst,
                           input bit known, input duty_t want_l, input duty_t want_r);
    duty_pair_t  p;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {e, c};
    do @(posedge clk); while (!s_tready);
    p = mix_and_slew(c, e);
    if (known) begin
      p.left  = want_l;
      p.right = want_r;
    end
    duty_q.push_back(p);
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected beat has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (duty_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    case (r)
      REG_BASE_SPEED: cur_base = v;
      REG_MAX_SPEED:  cur_max  = v;
      REG_ACCEL_MIN:  cur_amin = v;
      REG_ACCEL_MAX:  cur_amax = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random ready pattern plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rdy_left;
    int unsigned idle_left;
    int unsigned hold_left;
    rdy_left  = 0;
    idle_left = 0;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rdy_left > 0) begin
        rdy_left--;
        m_tready <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        m_tready <= 1'b0;
      end else begin
        rdy_left  = $urandom_range(0, 30);
        idle_left = pick_gap();
        m_tready <= 1'b1;
      end
    end
  end

  // Output check: each beat against the oldest expectation, field by field
  always @(posedge clk) begin
    duty_pair_t p;
    if (!rst && m_tvalid && m_tready) begin
      if (duty_q.size() == 0) begin
        flag_mismatch("beat with nothing expected, m_tdata", 0, m_tdata);
      end else begin
        p = duty_q.pop_front();
        if (m_tdata[7:0] !== p.left)   flag_mismatch("left_duty", p.left, m_tdata[7:0]);
        if (m_tdata[15:8] !== p.right) flag_mismatch("right_duty", p.right, m_tdata[15:8]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] rv [4];
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cur_base  = 8'd0;
    cur_max   = 8'd255;
    cur_amin  = 8'd0;
    cur_amax  = 8'd255;
    whl_l     = '0;
    whl_r     = '0;

    // After reset, then full steps, extremes, inverted accel range, zero step,
    // and max_speed dropped below the stored speeds
    dir_tbl.push_back(known_row(16'h0000, 16'h0000, 8'd0, 8'd0));
    dir_tbl.push_back(cfg_row(REG_BASE_SPEED, 8'd100));
    dir_tbl.push_back(cfg_row(REG_ACCEL_MIN, 8'd255));
    dir_tbl.push_back(known_row(16'h0000, 16'h0000, 8'd100, 8'd100));
    dir_tbl.push_back(known_row(16'h7FFF, 16'h0000, 8'd0, 8'd255));
    dir_tbl.push_back(known_row(16'h8000, 16'h8000, 8'd255, 8'd0));
    dir_tbl.push_back(cfg_row(REG_MAX_SPEED, 8'd50));
    dir_tbl.push_back(known_row(16'h0000, 16'h0000, 8'd50, 8'd50));
    dir_tbl.push_back(cfg_row(REG_MAX_SPEED, 8'd255));
    dir_tbl.push_back(cfg_row(REG_ACCEL_MIN, 8'd20));
    dir_tbl.push_back(cfg_row(REG_ACCEL_MAX, 8'd0));
    dir_tbl.push_back(tick_row(16'h0000, 16'h8000));
    dir_tbl.push_back(tick_row(16'h0064, 16'h06D6));
    dir_tbl.push_back(tick_row(16'hFF9C, 16'h0001));
    dir_tbl.push_back(tick_row(16'h0000, 16'h7FFF));
    dir_tbl.push_back(tick_row(16'h0032, 16'h0DAC));
    dir_tbl.push_back(tick_row(16'hFFCE, 16'hF254));
    dir_tbl.push_back(tick_row(16'h0000, 16'h0DAD));
    dir_tbl.push_back(cfg_row(REG_ACCEL_MIN, 8'd255));
    dir_tbl.push_back(cfg_row(REG_ACCEL_MAX, 8'd255));
    dir_tbl.push_back(cfg_row(REG_BASE_SPEED, 8'd200));
    dir_tbl.push_back(known_row(16'h0000, 16'h0000, 8'd200, 8'd200));
    dir_tbl.push_back(cfg_row(REG_MAX_SPEED, 8'd30));
    dir_tbl.push_back(cfg_row(REG_ACCEL_MIN, 8'd0));
    dir_tbl.push_back(cfg_row(REG_ACCEL_MAX, 8'd0));
    dir_tbl.push_back(known_row(16'h0000, 16'h0000, 8'd30, 8'd30));
    dir_tbl.push_back(tick_row(16'h5555, 16'hAAAA));
    dir_tbl.push_back(tick_row(16'hAAAA, 16'h5555));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg)
        write_reg(dir_tbl[i].reg_idx, dir_tbl[i].val);
      else
        send_tick(dir_tbl[i].corr, dir_tbl[i].err, 1'b0, dir_tbl[i].known,
                  dir_tbl[i].want_l, dir_tbl[i].want_r);
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       rv = '{8'd128, 8'd255, 8'd0,   8'd255};
        1:       rv = '{8'd255, 8'd255, 8'd255, 8'd0};
        2:       rv = '{8'd0,   8'd0,   8'd0,   8'd0};
        3:       rv = '{8'd90,  8'd180, 8'd2,   8'd40};
        default: rv = '{rand_reg_val(), rand_reg_val(), rand_reg_val(), rand_reg_val()};
      endcase
      write_reg(REG_BASE_SPEED, rv[0]);
      write_reg(REG_MAX_SPEED,  rv[1]);
      write_reg(REG_ACCEL_MIN,  rv[2]);
      write_reg(REG_ACCEL_MAX,  rv[3]);
      for (int i = 0; i < PHASE_TICKS; i++) begin
        // Long output hold-off while the input keeps pushing
        if (p == 3 && i == 40) hold_trigger = 1'b1;
        // Input pause until the pipe is empty
        if (p == 4 && i == 80) drain();
        send_tick(rand_field(300, 255), rand_field(4000, 3500),
                  (p == 3 && i >= 40 && i < 80), 1'b0, '0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && duty_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
sv/ddsl_pkg.sv
sv/ddsl_slew.sv
sv/differential_drive_slew_limiter.sv
tb/sv/differential_drive_slew_limiter_tb.sv
